>>> rtl/core/planar_odometry_integrator_defines.svh
// ----------------------------------------------------------------------------
// planar_odometry_integrator_defines
// Assertion macros for the pose integrator; empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef PLANAR_ODOMETRY_INTEGRATOR_DEFINES_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define POI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("poi same-cycle check failed");
`define POI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("poi next-cycle check failed");
`else
`define POI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define POI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/poi_pkg.sv
// ----------------------------------------------------------------------------
// poi_pkg
// Types, constants, arctangent table and multiply schedule of the pose
// integrator.
// ----------------------------------------------------------------------------
package poi_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam int VEL_W    = 16;
    localparam int POS_W    = 48;
    localparam int HEAD_W   = 32;
    localparam int IN_W     = 64;
    localparam int OUT_W    = 128;
    localparam int CS_W     = 33;
    localparam int Z_W      = 34;
    localparam int ATAN_W   = 30;
    localparam int MUL_A_W  = 34;
    localparam int MUL_B_W  = 18;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 64;
    localparam int WZ_W     = 33;
    localparam int OP_IDX_W = 4;

    localparam logic [OP_IDX_W-1:0] MAC_LAST = 4'd12;

    localparam logic [CS_W-1:0]  CORDIC_G = 33'd652032874;
    localparam logic [15:0]      KQ_HI    = 16'hA2F9;
    localparam logic [15:0]      KQ_LO    = 16'h836E;
    localparam logic [ACC_W-1:0] RND_POS  = 64'h0000_0008_0000_0000;
    localparam logic [ACC_W-1:0] RND_HEAD = 64'h0000_0000_8000_0000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CORDIC,
        S_MAC,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        A_COS,
        A_SIN,
        A_RXLO,
        A_RXHI,
        A_RYLO,
        A_RYHI,
        A_YAW,
        A_WZ
    } t_opa;

    typedef enum logic [2:0] {
        B_VF,
        B_VL,
        B_DT,
        B_KLO,
        B_KHI
    } t_opb;

    typedef enum logic [1:0] {
        SH_0,
        SH_16,
        SH_24
    } t_shift;

    typedef enum logic [1:0] {
        RND_ZERO_SEL,
        RND_POS_SEL,
        RND_HEAD_SEL
    } t_rnd;

    typedef enum logic [2:0] {
        D_NONE,
        D_RX,
        D_RY,
        D_WZ,
        D_X,
        D_Y,
        D_H
    } t_dest;

    typedef struct packed {
        t_opa   opa;
        t_opb   opb;
        logic   clr;
        logic   neg;
        t_shift sh;
        t_rnd   rnd;
        t_dest  dest;
    } t_mac_op;

    function automatic t_mac_op op_decode(input logic [OP_IDX_W-1:0] idx);
        t_mac_op op;
        op = '{opa: A_COS, opb: B_VF, clr: 1'b1, neg: 1'b0, sh: SH_0,
               rnd: RND_ZERO_SEL, dest: D_NONE};
        case (idx)
            4'd0: begin
                op.opa = A_COS;  op.opb = B_VF;
            end
            4'd1: begin
                op.opa = A_SIN;  op.opb = B_VL;  op.clr = 1'b0; op.neg = 1'b1;
                op.dest = D_RX;
            end
            4'd2: begin
                op.opa = A_SIN;  op.opb = B_VF;
            end
            4'd3: begin
                op.opa = A_COS;  op.opb = B_VL;  op.clr = 1'b0; op.dest = D_RY;
            end
            4'd4: begin
                op.opa = A_YAW;  op.opb = B_DT;  op.dest = D_WZ;
            end
            4'd5: begin
                op.opa = A_RXLO; op.opb = B_DT;  op.rnd = RND_POS_SEL;
            end
            4'd6: begin
                op.opa = A_RXHI; op.opb = B_DT;  op.clr = 1'b0; op.sh = SH_24;
                op.dest = D_X;
            end
            4'd7: begin
                op.opa = A_RYLO; op.opb = B_DT;  op.rnd = RND_POS_SEL;
            end
            4'd8: begin
                op.opa = A_RYHI; op.opb = B_DT;  op.clr = 1'b0; op.sh = SH_24;
                op.dest = D_Y;
            end
            4'd9: begin
                op.opa = A_WZ;   op.opb = B_KLO; op.rnd = RND_HEAD_SEL;
            end
            4'd10: begin
                op.opa = A_WZ;   op.opb = B_KHI; op.clr = 1'b0; op.sh = SH_16;
                op.dest = D_H;
            end
            default: begin
                op.dest = D_NONE;
            end
        endcase
        return op;
    endfunction

    // arctangent of 2^-i in 2^-32 turn
    function automatic logic [ATAN_W-1:0] atan_turn(input logic [4:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/planar_odometry_integrator.sv
// ----------------------------------------------------------------------------
// planar_odometry_integrator
// Dead-reckoning pose integrator: CORDIC sine/cosine of the heading, then a
// shared multiply-accumulate unit rotates and scales the body velocity and
// the yaw rate into x, y and heading increments.
// ----------------------------------------------------------------------------
// Channel  Dir  Width  Content
// s_axis   in   64     vel_forward, vel_lateral, yaw_rate, elapsed
// m_axis   out  128    pos_x, pos_y, heading
//
// One item runs CORDIC_STEPS shift-add CORDIC steps, one per cycle, then 11
// products through one 34x18 multiplier with a registered product and
// accumulator, then the result load.
// s_axis_tready is high only while idle. The next item may enter while a
// result still waits in the output register; it finishes only once that
// result is taken. Reset is synchronous and clears the pose to zero.
// ----------------------------------------------------------------------------
`include "planar_odometry_integrator_defines.svh"

module planar_odometry_integrator #(
    parameter int CORDIC_STEPS = poi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // vel_forward[15:0], vel_lateral[31:16], yaw_rate[47:32], elapsed[63:48]
    input  logic [poi_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // pos_x[47:0], pos_y[95:48], heading[127:96]
    output logic [poi_pkg::OUT_W-1:0] m_axis_tdata
);

    localparam int CNT_W = ($clog2(CORDIC_STEPS) > 4) ? $clog2(CORDIC_STEPS) : 4;
    localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORDIC_STEPS - 1);

    poi_pkg::t_state r_state;
    poi_pkg::t_state n_state;
    logic [CNT_W-1:0] r_cnt;

    logic signed [poi_pkg::VEL_W-1:0] r_vf;
    logic signed [poi_pkg::VEL_W-1:0] r_vl;
    logic signed [poi_pkg::VEL_W-1:0] r_wz;
    logic        [poi_pkg::VEL_W-1:0] r_dt;

    logic [poi_pkg::POS_W-1:0]  r_x;
    logic [poi_pkg::POS_W-1:0]  r_y;
    logic [poi_pkg::HEAD_W-1:0] r_h;

    logic signed [poi_pkg::CS_W-1:0] r_cx;
    logic signed [poi_pkg::CS_W-1:0] r_cy;
    logic signed [poi_pkg::Z_W-1:0]  r_z;
    logic signed [poi_pkg::CS_W-1:0] n_cx;
    logic signed [poi_pkg::CS_W-1:0] n_cy;
    logic signed [poi_pkg::Z_W-1:0]  n_z;
    logic signed [poi_pkg::CS_W-1:0] w_cx_sh;
    logic signed [poi_pkg::CS_W-1:0] w_cy_sh;
    logic        [poi_pkg::Z_W-1:0]  w_z_step;
    logic [4:0]                      w_idx;
    logic                            w_flip;
    logic [poi_pkg::HEAD_W-1:0]      w_zr;

    logic [poi_pkg::POS_W-1:0] r_rx;
    logic [poi_pkg::POS_W-1:0] r_ry;
    logic [poi_pkg::WZ_W-1:0]  r_wzdt;

    poi_pkg::t_mac_op w_op_m;
    poi_pkg::t_mac_op w_op_a;
    poi_pkg::t_mac_op w_op_c;
    logic [poi_pkg::OP_IDX_W-1:0] w_op_idx;

    logic signed [poi_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [poi_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [poi_pkg::PROD_W-1:0]  r_prod;
    logic signed [poi_pkg::ACC_W-1:0]   w_term;
    logic        [poi_pkg::ACC_W-1:0]   w_base;
    logic        [poi_pkg::ACC_W-1:0]   r_acc;
    logic        [poi_pkg::ACC_W-1:0]   n_acc;

    logic                       r_mvalid;
    logic [poi_pkg::OUT_W-1:0]  r_mdata;
    logic                       w_accept;
    logic                       w_out_load;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            poi_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = poi_pkg::S_CORDIC;
                end
            end
            poi_pkg::S_CORDIC: begin
                if (r_cnt == CORD_LAST) begin
                    n_state = poi_pkg::S_MAC;
                end
            end
            poi_pkg::S_MAC: begin
                if (r_cnt == CNT_W'(poi_pkg::MAC_LAST)) begin
                    n_state = poi_pkg::S_DONE;
                end
            end
            poi_pkg::S_DONE: begin
                if (!r_mvalid || m_axis_tready) begin
                    n_state = poi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = poi_pkg::S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_out_load    = 1'b0;
        case (r_state)
            poi_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            poi_pkg::S_DONE: begin
                w_out_load = !r_mvalid || m_axis_tready;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

    // CORDIC step
    assign w_flip   = r_h[31] ^ r_h[30];
    assign w_zr     = r_h ^ {w_flip, 31'b0};
    assign w_idx    = 5'(r_cnt);
    assign w_cx_sh  = r_cx >>> w_idx;
    assign w_cy_sh  = r_cy >>> w_idx;
    assign w_z_step = {4'b0, poi_pkg::atan_turn(w_idx)};

    always_comb begin
        if (!r_z[poi_pkg::Z_W-1]) begin
            n_cx = r_cx - w_cy_sh;
            n_cy = r_cy + w_cx_sh;
            n_z  = r_z - $signed(w_z_step);
        end else begin
            n_cx = r_cx + w_cy_sh;
            n_cy = r_cy - w_cx_sh;
            n_z  = r_z + $signed(w_z_step);
        end
    end

    // multiply schedule: product, accumulate and commit are one op apart
    assign w_op_idx = 4'(r_cnt);
    assign w_op_m   = poi_pkg::op_decode(w_op_idx);
    assign w_op_a   = poi_pkg::op_decode(w_op_idx - 4'd1);
    assign w_op_c   = poi_pkg::op_decode(w_op_idx - 4'd2);

    always_comb begin
        case (w_op_m.opa)
            poi_pkg::A_COS:  w_mul_a = {r_cx[poi_pkg::CS_W-1], r_cx};
            poi_pkg::A_SIN:  w_mul_a = {r_cy[poi_pkg::CS_W-1], r_cy};
            poi_pkg::A_RXLO: w_mul_a = {10'b0, r_rx[23:0]};
            poi_pkg::A_RXHI: w_mul_a = {{10{r_rx[47]}}, r_rx[47:24]};
            poi_pkg::A_RYLO: w_mul_a = {10'b0, r_ry[23:0]};
            poi_pkg::A_RYHI: w_mul_a = {{10{r_ry[47]}}, r_ry[47:24]};
            poi_pkg::A_YAW:  w_mul_a = {{18{r_wz[15]}}, r_wz};
            poi_pkg::A_WZ:   w_mul_a = {r_wzdt[poi_pkg::WZ_W-1], r_wzdt};
            default:         w_mul_a = '0;
        endcase
    end

    always_comb begin
        case (w_op_m.opb)
            poi_pkg::B_VF:  w_mul_b = {{2{r_vf[15]}}, r_vf};
            poi_pkg::B_VL:  w_mul_b = {{2{r_vl[15]}}, r_vl};
            poi_pkg::B_DT:  w_mul_b = {2'b0, r_dt};
            poi_pkg::B_KLO: w_mul_b = {2'b0, poi_pkg::KQ_LO};
            poi_pkg::B_KHI: w_mul_b = {2'b0, poi_pkg::KQ_HI};
            default:        w_mul_b = '0;
        endcase
    end

    always_comb begin
        case (w_op_a.sh)
            poi_pkg::SH_16: w_term = poi_pkg::ACC_W'(r_prod) <<< 16;
            poi_pkg::SH_24: w_term = poi_pkg::ACC_W'(r_prod) <<< 24;
            default:        w_term = poi_pkg::ACC_W'(r_prod);
        endcase
        if (w_op_a.clr) begin
            case (w_op_a.rnd)
                poi_pkg::RND_POS_SEL:  w_base = poi_pkg::RND_POS;
                poi_pkg::RND_HEAD_SEL: w_base = poi_pkg::RND_HEAD;
                default:               w_base = '0;
            endcase
        end else begin
            w_base = r_acc;
        end
        if (w_op_a.neg) begin
            n_acc = w_base - w_term;
        end else begin
            n_acc = w_base + w_term;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= poi_pkg::S_IDLE;
            r_cnt    <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_out_load) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    // pose accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
            r_h <= '0;
        end else if (r_state == poi_pkg::S_MAC) begin
            case (w_op_c.dest)
                poi_pkg::D_X: r_x <= r_x + {{20{r_acc[63]}}, r_acc[63:36]};
                poi_pkg::D_Y: r_y <= r_y + {{20{r_acc[63]}}, r_acc[63:36]};
                poi_pkg::D_H: r_h <= r_h + r_acc[63:32];
                default: begin
                    r_h <= r_h;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_vf <= s_axis_tdata[15:0];
            r_vl <= s_axis_tdata[31:16];
            r_wz <= s_axis_tdata[47:32];
            r_dt <= s_axis_tdata[63:48];
            r_cx <= w_flip ? (poi_pkg::CS_W'(0) - poi_pkg::CORDIC_G) : poi_pkg::CORDIC_G;
            r_cy <= '0;
            r_z  <= {{2{w_zr[31]}}, w_zr};
        end else if (r_state == poi_pkg::S_CORDIC) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_z  <= n_z;
        end
        if (r_state == poi_pkg::S_MAC) begin
            r_prod <= w_mul_a * w_mul_b;
            r_acc  <= n_acc;
            case (w_op_c.dest)
                poi_pkg::D_RX: r_rx   <= r_acc[47:0];
                poi_pkg::D_RY: r_ry   <= r_acc[47:0];
                poi_pkg::D_WZ: r_wzdt <= r_acc[32:0];
                default: begin
                    r_wzdt <= r_wzdt;
                end
            endcase
        end
        if (w_out_load) begin
            r_mdata <= {r_h, r_y, r_x};
        end
    end

    `POI_ASSERT_NEXT(a_accept_starts_cordic, i_clk, i_rst_n, w_accept, r_state == poi_pkg::S_CORDIC)
    `POI_ASSERT_NEXT(a_cordic_to_mac, i_clk, i_rst_n, (r_state == poi_pkg::S_CORDIC) && (r_cnt == CORD_LAST), (r_state == poi_pkg::S_MAC) && (r_cnt == '0))
    `POI_ASSERT_IMPL(a_mac_count_bound, i_clk, i_rst_n, r_state == poi_pkg::S_MAC, r_cnt <= CNT_W'(poi_pkg::MAC_LAST))
    `POI_ASSERT_NEXT(a_pose_hold, i_clk, i_rst_n, r_state != poi_pkg::S_MAC, $stable(r_x) && $stable(r_y) && $stable(r_h))

endmodule

>>> tb/planar_odometry_pose_checker.sv
// ----------------------------------------------------------------------------
// planar_odometry_pose_checker
// Watches both stream channels of the pose integrator. Every input transfer
// is run through a cycle-free predictor: CORDIC sine/cosine of the held
// heading, body-to-world rotation, scaling by elapsed time and wrapping
// accumulation. Every output transfer is compared field by field with the
// oldest predicted pose. Failures are counted for the testbench top.
// ----------------------------------------------------------------------------
module planar_odometry_pose_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_tvalid,
    input  logic                      i_in_tready,
    // vel_forward[15:0], vel_lateral[31:16], yaw_rate[47:32], elapsed[63:48]
    input  logic [poi_pkg::IN_W-1:0]  i_in_tdata,
    input  logic                      i_out_tvalid,
    input  logic                      i_out_tready,
    // pos_x[47:0], pos_y[95:48], heading[127:96]
    input  logic [poi_pkg::OUT_W-1:0] i_out_tdata,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked
);

    localparam int     ROT_STEPS       = 16;
    localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
    localparam longint YAW_TO_TURN_Q32 = 64'sd2734261102;
    localparam longint POS_HALF_LSB    = 64'sd34359738368;
    localparam longint HEAD_HALF_LSB   = 64'sd2147483648;

    typedef struct packed {
        logic [15:0]        elapsed;
        logic signed [15:0] yaw_rate;
        logic signed [15:0] vel_lateral;
        logic signed [15:0] vel_forward;
    } odo_sample_t;

    typedef struct packed {
        logic [31:0] heading;
        logic [47:0] pos_y;
        logic [47:0] pos_x;
    } pose_t;

    longint arctan_turns [32] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331, 21354465, 10679838, 5340245,
        2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304,
        652, 326, 163, 81,
        41, 20, 10, 5,
        3, 1, 1, 0
    };

    logic [47:0] pose_x       = '0;
    logic [47:0] pose_y       = '0;
    logic [31:0] pose_heading = '0;
    pose_t       expected_poses [$];
    int          fail_count   = 0;
    int          checked      = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_poses.size();
    assign o_checked    = checked;

    function automatic void heading_sin_cos(input logic [31:0] h, output longint cos_q30,
                                            output longint sin_q30);
        longint      vx;
        longint      vy;
        longint      nx;
        longint      ny;
        longint      z;
        logic [31:0] zr;
        int          i;
        vx = CORDIC_GAIN_Q30;
        vy = 0;
        zr = h;
        // fold the left half plane onto the right one
        if (h >= 32'h4000_0000 && h < 32'hC000_0000) begin
            vx = -vx;
            zr = h - 32'h8000_0000;
        end
        z = $signed(zr);
        for (i = 0; i < ROT_STEPS; i++) begin
            if (z >= 0) begin
                nx = vx - (vy >>> i);
                ny = vy + (vx >>> i);
                z  = z - arctan_turns[i];
            end else begin
                nx = vx + (vy >>> i);
                ny = vy - (vx >>> i);
                z  = z + arctan_turns[i];
            end
            vx = nx;
            vy = ny;
        end
        cos_q30 = vx;
        sin_q30 = vy;
    endfunction

    function automatic pose_t advance_pose(input odo_sample_t smp);
        longint c;
        longint s;
        longint vf;
        longint vl;
        longint wz;
        longint dt;
        longint rx;
        longint ry;
        longint dx;
        longint dy;
        longint dh;
        pose_t  p;
        vf = smp.vel_forward;
        vl = smp.vel_lateral;
        wz = smp.yaw_rate;
        dt = {48'd0, smp.elapsed};
        heading_sin_cos(pose_heading, c, s);
        rx = vf * c - vl * s;
        ry = vf * s + vl * c;
        dx = (rx * dt + POS_HALF_LSB) >>> 36;
        dy = (ry * dt + POS_HALF_LSB) >>> 36;
        dh = (wz * dt * YAW_TO_TURN_Q32 + HEAD_HALF_LSB) >>> 32;
        pose_x       = pose_x + dx[47:0];
        pose_y       = pose_y + dy[47:0];
        pose_heading = pose_heading + dh[31:0];
        p.pos_x   = pose_x;
        p.pos_y   = pose_y;
        p.heading = pose_heading;
        return p;
    endfunction

    always @(posedge i_clk) begin
        pose_t got;
        pose_t want;
        if (!i_rst_n) begin
            pose_x       = '0;
            pose_y       = '0;
            pose_heading = '0;
            expected_poses.delete();
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                got = pose_t'(i_out_tdata);
                if (expected_poses.size() == 0) begin
                    $error("pose transfer with none pending: %h", i_out_tdata);
                    fail_count++;
                end else begin
                    want = expected_poses.pop_front();
                    if (got.pos_x !== want.pos_x) begin
                        $error("pos_x: expected %h, actual %h", want.pos_x, got.pos_x);
                        fail_count++;
                    end
                    if (got.pos_y !== want.pos_y) begin
                        $error("pos_y: expected %h, actual %h", want.pos_y, got.pos_y);
                        fail_count++;
                    end
                    if (got.heading !== want.heading) begin
                        $error("heading: expected %h, actual %h", want.heading, got.heading);
                        fail_count++;
                    end
                end
                checked++;
            end
            if (i_in_tvalid && i_in_tready) begin
                expected_poses.push_back(advance_pose(odo_sample_t'(i_in_tdata)));
            end
        end
    end

endmodule

>>> tb/planar_odometry_integrator_tb.sv
// ----------------------------------------------------------------------------
// planar_odometry_integrator_tb
// Drives velocity/yaw/elapsed samples into the pose integrator: a directed
// set of field extremes, zero elapsed time and heading wrap in both
// directions, then random samples with random gaps and back-pressure, two
// long output hold-offs and one full drain. A separate checker predicts and
// compares every pose; this top gives the verdict.
// ----------------------------------------------------------------------------
module planar_odometry_integrator_tb;

    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 64;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [poi_pkg::IN_W-1:0]  s_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [poi_pkg::OUT_W-1:0] m_axis_tdata;

    int fail_count;
    int pose_pending;
    int poses_checked;
    int cycle_count   = 0;
    int results_taken = 0;
    int directed_sent = 0;
    int random_sent   = 0;
    bit sender_busy   = 1'b0;
    bit receiver_busy = 1'b0;

    planar_odometry_integrator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    planar_odometry_pose_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pose_pending),
        .o_checked    (poses_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL planar_odometry_integrator");
            $finish;
        end
    end

    function automatic logic [63:0] pack_sample(input logic [15:0] vf, input logic [15:0] vl,
                                                input logic [15:0] wz, input logic [15:0] dt);
        return {dt, wz, vl, vf};
    endfunction

    function automatic logic [15:0] pick_signed();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'h8000;
            1: v = 16'h7FFF;
            2: v = 16'h0000;
            3: v = 16'($urandom_range(0, 63)) - 16'd32;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_elapsed();
        logic [15:0] v;
        case ($urandom_range(0, 11))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2: v = 16'($urandom_range(1, 16));
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // present one sample and hold it until transferred; returns at a falling edge
    task automatic put_sample(input logic [63:0] d);
        int gap;
        gap = sender_busy ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    initial begin
        int stall;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            stall = receiver_busy ? 0 : $urandom_range(0, 4);
            if (results_taken == 40 || results_taken == 1100) begin
                stall = HOLD_CYCLES;
            end
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            results_taken++;
        end
    end

    initial begin
        int i;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        put_sample(pack_sample(16'h1000, 16'hF000, 16'h0500, 16'h0000));
        put_sample(pack_sample(16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF));
        put_sample(pack_sample(16'h8000, 16'h8000, 16'h0000, 16'hFFFF));
        put_sample(pack_sample(16'h0000, 16'h7FFF, 16'h0000, 16'hFFFF));
        put_sample(pack_sample(16'h0000, 16'h8000, 16'h0000, 16'h0001));
        put_sample(pack_sample(16'h0000, 16'h0000, 16'h7FFF, 16'hFFFF));
        put_sample(pack_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF));
        put_sample(pack_sample(16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF));
        put_sample(pack_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF));
        put_sample(pack_sample(16'h1234, 16'hABCD, 16'h7FFF, 16'h0000));
        put_sample(pack_sample(16'h7FFF, 16'h0000, 16'h7FFF, 16'hFFFF));
        for (i = 0; i < 6; i++) begin
            put_sample(pack_sample(16'h4000, 16'hC000, 16'h8000, 16'hFFFF));
        end
        put_sample(pack_sample(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001));
        put_sample(pack_sample(16'h7FFF, 16'h7FFF, 16'h0001, 16'hFFFF));
        put_sample(pack_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        put_sample(pack_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        directed_sent = 21;

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 150 == 0) begin
                sender_busy   = ($urandom_range(0, 3) == 0);
                receiver_busy = ($urandom_range(0, 3) == 0);
            end
            if (i == 900) begin
                s_axis_tvalid <= 1'b0;
                wait (pose_pending == 0);
                @(negedge i_clk);
            end
            put_sample(pack_sample(pick_signed(), pick_signed(), pick_signed(), pick_elapsed()));
            random_sent++;
        end
        s_axis_tvalid <= 1'b0;

        wait (pose_pending == 0);
        repeat (SETTLE) @(posedge i_clk);
        $display("Covered %0d directed and %0d random samples, %0d poses checked",
                 directed_sent, random_sent, poses_checked);
        $display("Included zero elapsed, heading wrap both ways, two output hold-offs, a drain");
        if (fail_count == 0) begin
            $display("PASS planar_odometry_integrator");
        end else begin
            $display("FAIL planar_odometry_integrator");
        end
        $finish;
    end

endmodule
